>>> src/lsh_hash_to_bucket_index_defines.svh
// ----------------------------------------------------------------------------
// LSH bucket index combiner - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LSH_HASH_TO_BUCKET_INDEX_DEFINES_SVH
`define LSH_HASH_TO_BUCKET_INDEX_DEFINES_SVH

// same-cycle implication
`define LHBI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LHBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lhbi_pkg.sv
// ----------------------------------------------------------------------------
// LSH bucket index combiner - package
// Widths, limits, register indexes, mode and command codes.
// ----------------------------------------------------------------------------
package lhbi_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MIX_W     = 31;
  localparam int unsigned MIX_DEPTH = 1024;
  localparam int unsigned MIX_AW    = $clog2(MIX_DEPTH);
  localparam int unsigned MIX_SHIFT = 13;
  localparam int unsigned HPOS_W    = 4;
  localparam int unsigned TPOS_W    = 6;
  localparam int unsigned K_W       = 5;
  localparam int unsigned L_W       = 7;
  localparam int unsigned RB_W      = 5;
  localparam int unsigned SH_W      = 5;
  localparam int unsigned MODE_W    = 3;

  // count limits
  localparam logic [K_W-1:0] K_MAX = 5'd16;
  localparam logic [L_W-1:0] L_MAX = 7'd64;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASHES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WTA_SHIFT = 3'd4;

  // register reset values
  localparam logic [MODE_W-1:0] RST_MODE      = 3'd0;
  localparam logic [K_W-1:0]    RST_HASHES    = 5'd6;
  localparam logic [L_W-1:0]    RST_TABLES    = 7'd50;
  localparam logic [RB_W-1:0]   RST_RANGE     = 5'd9;
  localparam logic [SH_W-1:0]   RST_WTA_SHIFT = 5'd2;

  // modes; codes from four up all mix, only top-k masks
  localparam logic [MODE_W-1:0] MODE_SIMHASH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WTA     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DWTA    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOPK    = 3'd3;

  // input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_HASH = 1'b1;

endpackage

>>> src/lhbi_if.sv
// ----------------------------------------------------------------------------
// LSH bucket index combiner - channel interfaces
// Valid/ready channels for input items and bucket index results.
// ----------------------------------------------------------------------------
interface lhbi_in_if;
  import lhbi_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [MIX_AW-1:0]   word_index;
  logic [MIX_W-1:0]    mix_word;
  logic [WORD_W-1:0]   hash_value;

  modport source (output valid, command, word_index, mix_word, hash_value, input ready);
  modport sink   (input valid, command, word_index, mix_word, hash_value, output ready);
endinterface

interface lhbi_out_if;
  import lhbi_pkg::*;

  logic                valid;
  logic                ready;
  logic [TPOS_W-1:0]   table_number;
  logic [WORD_W-1:0]   bucket_index;
  logic                last_table;

  modport source (output valid, table_number, bucket_index, last_table, input ready);
  modport sink   (input valid, table_number, bucket_index, last_table, output ready);
endinterface

>>> src/lhbi_mix_mem.sv
// ----------------------------------------------------------------------------
// LSH bucket index combiner - mix word memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module lhbi_mix_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [lhbi_pkg::MIX_AW-1:0]  waddr_i,
  input  logic [lhbi_pkg::MIX_W-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [lhbi_pkg::MIX_AW-1:0]  raddr_i,
  output logic [lhbi_pkg::MIX_W-1:0]   rdata_o
);
  import lhbi_pkg::*;

  logic [MIX_W-1:0] mem_q [MIX_DEPTH];
  logic [MIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lhbi_mul.sv
// ----------------------------------------------------------------------------
// LSH bucket index combiner - shared multiplier
// 32x32 multiply, low word kept, product registered.
// ----------------------------------------------------------------------------
module lhbi_mul (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lhbi_pkg::WORD_W-1:0]  a_i,
  input  logic [lhbi_pkg::WORD_W-1:0]  b_i,
  output logic [lhbi_pkg::WORD_W-1:0]  prod_o
);
  import lhbi_pkg::*;

  logic [WORD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;  // modulo 2^32
    end
  end

  assign prod_o = prod_q;

endmodule

>>> src/lsh_hash_to_bucket_index.sv
// ----------------------------------------------------------------------------
// LSH bucket index combiner
// Folds groups of hash values into one 32-bit bucket index per table.
// ----------------------------------------------------------------------------
// Hash values arrive table-major, hashes_per_table per table. A load command
// stores one mix word. A hash in simhash, WTA or DWTA mode is accepted, then
// accumulated; in the mixing modes it is accepted with the mix word read,
// squared, mix multiplied and accumulated, since one 32x32 multiplier is used
// twice per hash. The last hash of a table then passes a finish state that
// hands the index to the output register, and waits there while an earlier
// result is still untaken. The input is not ready while a hash is in flight.
// Mix words must be loaded before any hash reads them.
`include "lsh_hash_to_bucket_index_defines.svh"

module lsh_hash_to_bucket_index (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lhbi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lhbi_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  lhbi_in_if.sink                          in_if,
  lhbi_out_if.source                       out_if
);
  import lhbi_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_MX   = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [MODE_W-1:0] mode_q;
  logic [K_W-1:0]    hpt_q;
  logic [L_W-1:0]    tcnt_q;
  logic [RB_W-1:0]   range_q;
  logic [SH_W-1:0]   wta_q;

  // group state
  logic [WORD_W-1:0] acc_q;
  logic [HPOS_W-1:0] hp_q;
  logic [TPOS_W-1:0] tp_q;
  logic [WORD_W-1:0] hash_q;

  // output register
  logic              out_valid_q;
  logic [TPOS_W-1:0] out_tn_q;
  logic [WORD_W-1:0] out_bi_q;
  logic              out_lt_q;

  logic              in_fire, emit, shift_mode;
  logic [K_W-1:0]    k;
  logic [L_W-1:0]    l;
  logic [K_W-1:0]    hp_inc, rem_full;
  logic [HPOS_W-1:0] rem;
  logic              last_hash, last_tab;
  logic [L_W-1:0]    tp_inc;
  logic [8:0]        wta_amt;
  logic [10:0]       addr_full;
  logic [RB_W-1:0]   rb;
  logic [WORD_W-1:0] topk_mask, term, acc_sum;
  logic [MIX_W-1:0]  mix_rdata;
  logic [WORD_W-1:0] mix_ext, mixed, mul_a, mul_b, prod;
  logic              mul_en;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign emit        = (state_q == ST_FIN) && (!out_valid_q || out_if.ready);
  assign shift_mode  = (mode_q == MODE_SIMHASH) || (mode_q == MODE_WTA) ||
                       (mode_q == MODE_DWTA);

  // clamped counts and positions
  always_comb begin
    if (hpt_q == '0) begin
      k = 5'd1;
    end else if (hpt_q > K_MAX) begin
      k = K_MAX;
    end else begin
      k = hpt_q;
    end
    if (tcnt_q == '0) begin
      l = 7'd1;
    end else if (tcnt_q > L_MAX) begin
      l = L_MAX;
    end else begin
      l = tcnt_q;
    end
  end

  assign hp_inc    = {1'b0, hp_q} + 5'd1;
  assign last_hash = (hp_inc >= k);
  assign rem_full  = k - hp_inc;
  // a position past a shrunk count closes the table with no shift
  assign rem       = last_hash ? '0 : rem_full[HPOS_W-1:0];
  assign tp_inc    = {1'b0, tp_q} + 7'd1;
  assign last_tab  = (tp_inc >= l);

  assign wta_amt   = {5'b0, rem} * {4'b0, wta_q};
  assign addr_full = ({5'b0, tp_q} * {6'b0, k}) + {7'b0, hp_q};

  assign rb        = (range_q == '0) ? 5'd1 : range_q;
  assign topk_mask = (32'd1 << rb) - 32'd1;

  // per-hash contribution
  always_comb begin
    priority if (mode_q == MODE_SIMHASH) begin
      term = hash_q << rem;
    end else if (mode_q == MODE_WTA || mode_q == MODE_DWTA) begin
      term = (wta_amt >= 9'd32) ? '0 : (hash_q << wta_amt[4:0]);
    end else begin
      term = prod;
    end
  end

  assign acc_sum = acc_q + term;

  // shared multiplier: w*w, then mixed*hash
  assign mix_ext = {1'b0, mix_rdata};
  assign mixed   = prod ^ (prod >> MIX_SHIFT) ^ mix_ext;
  assign mul_en  = (state_q == ST_SQ) || (state_q == ST_MX);
  assign mul_a   = (state_q == ST_MX) ? mixed : mix_ext;
  assign mul_b   = (state_q == ST_MX) ? hash_q : mix_ext;

  lhbi_mix_mem u_mix_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire && in_if.command == CMD_LOAD),
    .waddr_i (in_if.word_index),
    .wdata_i (in_if.mix_word),
    .re_i    (in_fire && in_if.command == CMD_HASH),
    .raddr_i (addr_full[MIX_AW-1:0]),
    .rdata_o (mix_rdata)
  );

  lhbi_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_if.command == CMD_HASH) begin
          state_d = shift_mode ? ST_ACC : ST_SQ;
        end
      end
      ST_SQ:  state_d = ST_MX;
      ST_MX:  state_d = ST_ACC;
      ST_ACC: state_d = last_hash ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= RST_MODE;
      hpt_q   <= RST_HASHES;
      tcnt_q  <= RST_TABLES;
      range_q <= RST_RANGE;
      wta_q   <= RST_WTA_SHIFT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:      mode_q  <= cfg_wdata_i[MODE_W-1:0];
        CFG_HASHES:    hpt_q   <= cfg_wdata_i[K_W-1:0];
        CFG_TABLES:    tcnt_q  <= cfg_wdata_i[L_W-1:0];
        CFG_RANGE:     range_q <= cfg_wdata_i[RB_W-1:0];
        CFG_WTA_SHIFT: wta_q   <= cfg_wdata_i[SH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      hp_q  <= '0;
      tp_q  <= '0;
    end else if (state_q == ST_ACC) begin
      if (last_hash) begin
        acc_q <= (mode_q == MODE_TOPK) ? (acc_sum & topk_mask) : acc_sum;
      end else begin
        acc_q <= acc_sum;
        hp_q  <= hp_q + 4'd1;
      end
    end else if (emit) begin
      acc_q <= '0;
      hp_q  <= '0;
      tp_q  <= last_tab ? '0 : tp_inc[TPOS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_if.command == CMD_HASH) begin
      hash_q <= in_if.hash_value;
    end
  end

  // result register; a new result may load as the old one transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_tn_q <= tp_q;
      out_bi_q <= acc_q;
      out_lt_q <= last_tab;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.table_number = out_tn_q;
  assign out_if.bucket_index = out_bi_q;
  assign out_if.last_table   = out_lt_q;

  `LHBI_ASSERT_IMP(a_mx_after_sq, clk_i, rst_ni, state_q == ST_MX, $past(state_q) == ST_SQ, "mix multiply without square")
  `LHBI_ASSERT_IMP(a_fin_on_last, clk_i, rst_ni, state_q == ST_FIN && $past(state_q) == ST_ACC, $past(last_hash), "table closed early")
  `LHBI_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, emit, hp_q == '0 && acc_q == '0 && out_if.valid, "group state not cleared on result")
  `LHBI_ASSERT_NEXT(a_load_idle, clk_i, rst_ni, in_fire && in_if.command == CMD_LOAD, state_q == ST_IDLE, "load started work")

endmodule
